/* hdl/ssr_pkg.sv */
// Shared types, item codes and coil sequence tables of the stepper sequencer.
package ssr_pkg;

  // Item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Sequence modes (anything at or above MODE_HALF is half step)
  localparam logic [1:0] MODE_WAVE = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  localparam int unsigned TBL_DEPTH = 256;
  localparam int unsigned TBL_AW    = 8;

  localparam logic [3:0] WAVE_PAT [4] = '{4'd1, 4'd4, 4'd2, 4'd8};
  localparam logic [3:0] FULL_PAT [4] = '{4'd5, 4'd6, 4'd10, 4'd9};
  localparam logic [3:0] HALF_PAT [8] = '{4'd1, 4'd5, 4'd4, 4'd6,
                                          4'd2, 4'd10, 4'd8, 4'd9};

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  table_index;
    logic [31:0] table_value;
    logic [1:0]  seq_mode;
    logic        direction;
    logic [15:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       step_pulse;
    logic       running;
  } out_item_t;

  function automatic logic [3:0] seq_pattern(input logic [1:0] mode, input logic [2:0] ph);
    logic [3:0] pat;
    case (mode)
      MODE_WAVE: pat = WAVE_PAT[ph[1:0]];
      MODE_FULL: pat = FULL_PAT[ph[1:0]];
      default:   pat = HALF_PAT[ph];
    endcase
    return pat;
  endfunction

endpackage

/* hdl/ssr_if.sv */
// Valid/ready channel interfaces for input and result transactions.
interface ssr_in_if import ssr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssr_out_if import ssr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/ssr_out_fifo.sv */
// Two-entry result queue that decouples the sequencer from the output channel.
module ssr_out_fifo import ssr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  output logic      full_o,
  ssr_out_if.source out_o
);

  out_item_t  entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop        = out_o.valid & out_o.ready;
  assign out_o.valid = (count_q != 2'd0);
  assign out_o.data  = entry_q[rd_ptr_q];
  assign full_o      = (count_q == 2'd2);

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* hdl/stepper_sequencer_with_ramp.sv */
// Top level: four-coil stepper sequencer with trapezoidal interval ramp.
//
//  channel | dir | payload    | transaction
//  --------+-----+------------+----------------------------------------------
//  in_i    | in  | in_item_t  | load table entry, start run or timer tick
//  out_o   | out | out_item_t | coils, step_pulse, running (one per input)
//
// One input transaction per clock while the result queue has room; every
// transaction is handled in the cycle it is taken. The interval table is a 256x32
// synchronous RAM, read every cycle at the entry the next step will need, so its
// data is ready in the next cycle; a load to that same entry is forwarded. Reset
// clears control state at once; table contents stay undefined until loaded.
// Results go through a two-entry queue; in_i.ready drops only while both are held.
module stepper_sequencer_with_ramp import ssr_pkg::*; #(
  parameter int unsigned ACCEL_STEPS = 256,
  parameter int unsigned DECEL_STEPS = 256,
  parameter int unsigned MAX_STEPS   = 65535
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssr_in_if.sink    in_i,
  ssr_out_if.source out_o
);

  localparam logic [15:0] MaxLen   = 16'(MAX_STEPS);
  localparam logic [15:0] AccelLen = 16'(ACCEL_STEPS);
  localparam logic [15:0] DecelLen = 16'(DECEL_STEPS);
  localparam logic [16:0] RampSum  = 17'(ACCEL_STEPS + DECEL_STEPS);

  // Interval table
  logic [31:0]       tbl_mem [TBL_DEPTH];
  logic [31:0]       rd_data_q;
  logic [TBL_AW-1:0] rd_addr;
  logic              tbl_we;
  logic              byp_q, byp_d;
  logic [31:0]       byp_data_q;
  logic [31:0]       tbl_val;

  // Sequencer state
  logic [31:0] match_q, match_d;
  logic [31:0] tick_q, tick_d;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] step_q, step_d;
  logic [15:0] total_q, total_d;
  logic [15:0] accel_q, accel_d;
  logic [15:0] const_q, const_d;
  logic [15:0] decel_q, decel_d;
  logic [1:0]  mode_q, mode_d;
  logic        dir_q, dir_d;
  logic        run_q, run_d;
  logic [3:0]  coil_q, coil_d;
  logic        pulse;

  // Start decode
  logic [15:0] len_clip;
  logic [15:0] half_len;
  logic [15:0] a_len, d_len;
  logic [2:0]  last_ph;
  logic        fifo_full;
  logic        acc;
  out_item_t   res;

  assign in_i.ready = ~fifo_full;
  assign acc        = in_i.valid & ~fifo_full;
  assign tbl_val    = byp_q ? byp_data_q : rd_data_q;
  assign tbl_we     = acc && (in_i.data.kind == KIND_LOAD);

  always_comb begin
    len_clip = (in_i.data.run_length > MaxLen) ? MaxLen : in_i.data.run_length;
    half_len = len_clip >> 1;
    if ({1'b0, len_clip} >= RampSum) begin
      a_len = AccelLen;
      d_len = DecelLen;
    end else begin
      a_len = half_len;
      d_len = half_len;
    end
    last_ph = (mode_q >= MODE_HALF) ? 3'd7 : 3'd3;
  end

  always_comb begin
    match_d = match_q;
    tick_d  = tick_q;
    phase_d = phase_q;
    step_d  = step_q;
    total_d = total_q;
    accel_d = accel_q;
    const_d = const_q;
    decel_d = decel_q;
    mode_d  = mode_q;
    dir_d   = dir_q;
    run_d   = run_q;
    coil_d  = coil_q;
    pulse   = 1'b0;
    if (acc) begin
      case (in_i.data.kind)
        KIND_LOAD: begin
          if (in_i.data.table_index == '0) begin
            match_d = in_i.data.table_value;
          end
        end
        KIND_START: begin
          total_d = len_clip;
          accel_d = a_len;
          decel_d = d_len;
          const_d = len_clip - (a_len + d_len);
          mode_d  = in_i.data.seq_mode;
          dir_d   = in_i.data.direction;
          phase_d = (in_i.data.seq_mode >= MODE_HALF) ? phase_q : {1'b0, phase_q[1:0]};
          step_d  = '0;
          tick_d  = '0;
          run_d   = 1'b1;
        end
        KIND_TICK: begin
          if (run_q) begin
            if (tick_q != match_q) begin
              tick_d = tick_q + 32'd1;
            end else begin
              pulse  = 1'b1;
              tick_d = '0;
              coil_d = seq_pattern(mode_q, phase_q);
              if (!dir_q) begin
                phase_d = (phase_q == last_ph) ? 3'd0 : phase_q + 3'd1;
              end else begin
                phase_d = (phase_q == 3'd0) ? last_ph : phase_q - 3'd1;
              end
              // ramp up, hold, or ramp down through the table
              if (step_q < accel_q) begin
                match_d = tbl_val;
              end else if ({1'b0, step_q} > ({1'b0, accel_q} + {1'b0, const_q})) begin
                decel_d = decel_q - 16'd1;
                match_d = tbl_val;
              end
              if (step_q >= total_q) begin
                run_d  = 1'b0;
                step_d = '0;
              end else begin
                step_d = step_q + 16'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Prefetch the entry the next step would read
  always_comb begin
    logic [15:0] dec_m1;
    dec_m1  = decel_d - 16'd1;
    rd_addr = (step_d < accel_d) ? step_d[TBL_AW-1:0] : dec_m1[TBL_AW-1:0];
    byp_d   = tbl_we && (in_i.data.table_index == rd_addr);
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[in_i.data.table_index] <= in_i.data.table_value;
    end
    rd_data_q  <= tbl_mem[rd_addr];
    byp_data_q <= in_i.data.table_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      tick_q  <= '0;
      phase_q <= '0;
      step_q  <= '0;
      total_q <= '0;
      accel_q <= '0;
      const_q <= '0;
      decel_q <= '0;
      mode_q  <= MODE_WAVE;
      dir_q   <= 1'b0;
      run_q   <= 1'b0;
      coil_q  <= '0;
      byp_q   <= 1'b0;
    end else begin
      match_q <= match_d;
      tick_q  <= tick_d;
      phase_q <= phase_d;
      step_q  <= step_d;
      total_q <= total_d;
      accel_q <= accel_d;
      const_q <= const_d;
      decel_q <= decel_d;
      mode_q  <= mode_d;
      dir_q   <= dir_d;
      run_q   <= run_d;
      coil_q  <= coil_d;
      byp_q   <= byp_d;
    end
  end

  assign res.coils      = coil_d;
  assign res.step_pulse = pulse;
  assign res.running    = run_d;

  ssr_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (acc),
    .item_i (res),
    .full_o (fifo_full),
    .out_o  (out_o)
  );

  a_step_clears_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse |=> (tick_q == '0))
    else $error("tick count not cleared after a step");

  a_run_ends_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(run_q) |-> $past(pulse))
    else $error("run stopped without a final step");

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q < MODE_HALF) |-> (phase_q < 3'd4))
    else $error("phase index outside four-step sequence");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= total_q)
    else $error("step count passed run length");

endmodule

/* tb/sv/testbench.sv */
// Testbench for the stepper sequencer: directed table plus random transactions vs. a predictor.
`timescale 1ns / 100ps

module testbench import ssr_pkg::*;;

  localparam int unsigned ACCEL_STEPS = 256;
  localparam int unsigned DECEL_STEPS = 256;
  localparam int unsigned MAX_STEPS   = 65535;

  localparam logic [1:0] KIND_NONE     = 2'd3;
  localparam logic [1:0] MODE_HALF_ALT = 2'd3;

  // coil patterns packed one nibble per phase, phase 0 in the low nibble
  localparam logic [15:0] WAVE_COILS = 16'h8241;
  localparam logic [15:0] FULL_COILS = 16'h9A65;
  localparam logic [31:0] HALF_COILS = 32'h98A2_6451;

  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ssr_in_if  in_if ();
  ssr_out_if out_if ();

  stepper_sequencer_with_ramp #(
    .ACCEL_STEPS(ACCEL_STEPS),
    .DECEL_STEPS(DECEL_STEPS),
    .MAX_STEPS  (MAX_STEPS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor state
  logic [31:0] interval_mem [TBL_DEPTH];
  logic [31:0] cur_match;
  logic [31:0] tick_cnt;
  logic [2:0]  phase;
  logic [15:0] steps_done;
  logic [15:0] run_total;
  logic [15:0] ramp_up_len;
  logic [15:0] hold_len;
  logic [15:0] ramp_down_idx;
  logic [1:0]  mode_q;
  logic        dir_q;
  logic        busy;
  logic [3:0]  coil_q;

  out_item_t pending_outputs [$];
  out_item_t oldest_expected;

  // random stimulus state
  bit       restore_pending = 1'b0;
  bit [7:0] restore_index;
  int       fill_next       = 0;
  int       random_picks    = 0;
  bit       long_run_active = 1'b0;
  bit       long_run_used   = 1'b0;
  bit       in_burst        = 1'b0;
  bit       out_burst       = 1'b0;

  int mismatches      = 0;
  int results_checked = 0;
  int sent            = 0;
  int runs_started    = 0;
  int restarts        = 0;
  int runs_completed  = 0;
  int steps_issued    = 0;
  int longest_run     = 0;

  logic      out_fire = 1'b0;
  out_item_t out_seen;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [3:0] coil_pattern(input logic [1:0] mode, input logic [2:0] ph);
    if (mode == MODE_WAVE) return WAVE_COILS[{ph[1:0], 2'b00} +: 4];
    if (mode == MODE_FULL) return FULL_COILS[{ph[1:0], 2'b00} +: 4];
    return HALF_COILS[{ph, 2'b00} +: 4];
  endfunction

  function automatic out_item_t advance_motor(input in_item_t it);
    out_item_t   res;
    logic [15:0] len;
    logic [15:0] up;
    logic [15:0] down;
    logic [2:0]  last;
    res.step_pulse = 1'b0;
    case (it.kind)
      KIND_LOAD: begin
        interval_mem[it.table_index] = it.table_value;
        if (it.table_index == 8'd0) cur_match = it.table_value;
      end
      KIND_START: begin
        len = it.run_length;
        if (32'(len) > MAX_STEPS) len = 16'(MAX_STEPS);
        if (32'(len) >= ACCEL_STEPS + DECEL_STEPS) begin
          up   = 16'(ACCEL_STEPS);
          down = 16'(DECEL_STEPS);
        end else begin
          up   = len >> 1;
          down = up;
        end
        run_total     = len;
        ramp_up_len   = up;
        ramp_down_idx = down;
        hold_len      = len - up - down;
        mode_q        = it.seq_mode;
        dir_q         = it.direction;
        phase         = phase & ((mode_q >= MODE_HALF) ? 3'd7 : 3'd3);
        steps_done    = '0;
        tick_cnt      = '0;
        busy          = 1'b1;
      end
      KIND_TICK: if (busy) begin
        if (tick_cnt != cur_match) begin
          tick_cnt = tick_cnt + 32'd1;
        end else begin
          last     = (mode_q >= MODE_HALF) ? 3'd7 : 3'd3;
          tick_cnt = '0;
          coil_q   = coil_pattern(mode_q, phase);
          if (!dir_q) phase = (phase == last) ? 3'd0 : phase + 3'd1;
          else        phase = (phase == 3'd0) ? last : phase - 3'd1;
          // ramp up, hold through the constant stretch, then walk back down
          if (steps_done < ramp_up_len) begin
            cur_match = interval_mem[steps_done[7:0]];
          end else if (32'(steps_done) > 32'(ramp_up_len) + 32'(hold_len)) begin
            ramp_down_idx = ramp_down_idx - 16'd1;
            cur_match     = interval_mem[ramp_down_idx[7:0]];
          end
          if (steps_done >= run_total) begin
            busy       = 1'b0;
            steps_done = '0;
            tick_cnt   = '0;
          end else begin
            steps_done = steps_done + 16'd1;
          end
          res.step_pulse = 1'b1;
        end
      end
      default: ;
    endcase
    res.coils   = coil_q;
    res.running = busy;
    return res;
  endfunction

  // mostly zero so most steps come on every tick
  function automatic logic [31:0] short_interval();
    return ($urandom_range(0, 9) < 7) ? 32'd0 : 32'($urandom_range(1, 3));
  endfunction

  function automatic logic [15:0] run_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 16'($urandom_range(0, 40));
    if (r < 95) return 16'($urandom_range(41, 520));
    return 16'($urandom);
  endfunction

  function automatic in_item_t pick_item();
    in_item_t it;
    int       r;
    it.kind        = KIND_TICK;
    it.table_index = 8'($urandom);
    it.table_value = $urandom;
    it.seq_mode    = 2'($urandom);
    it.direction   = 1'($urandom);
    it.run_length  = 16'($urandom);
    random_picks++;
    // a huge interval is always overwritten by the very next transaction
    if (restore_pending) begin
      restore_pending = 1'b0;
      it.kind         = KIND_LOAD;
      it.table_index  = restore_index;
      it.table_value  = short_interval();
      return it;
    end
    // fill the whole table first so no ramp ever reads an unwritten entry
    if (fill_next < TBL_DEPTH) begin
      it.kind        = KIND_LOAD;
      it.table_index = 8'(fill_next);
      it.table_value = short_interval();
      fill_next++;
      return it;
    end
    r = $urandom_range(0, 99);
    if (busy) begin
      if (long_run_active) begin
        it.kind = (r < 98) ? KIND_TICK : KIND_NONE;
      end else if (r < 88) begin
        it.kind = KIND_TICK;
      end else if (r < 92) begin
        it.kind = KIND_LOAD;
        // entry 0 retargets the live match; keep it at or above the count
        if (it.table_index == 8'd0) it.table_value = tick_cnt + 32'($urandom_range(0, 2));
        else it.table_value = short_interval();
      end else if (r < 97) begin
        it.kind       = KIND_START;
        it.run_length = run_request();
      end else begin
        it.kind = KIND_NONE;
      end
    end else begin
      long_run_active = 1'b0;
      if (!long_run_used && random_picks > 400) begin
        // one full trapezoid: both ramps of the table plus a constant stretch, which may be empty
        long_run_used   = 1'b1;
        long_run_active = 1'b1;
        it.kind         = KIND_START;
        it.run_length   = 16'($urandom_range(512, 560));
      end else if (r < 55) begin
        it.kind       = KIND_START;
        it.run_length = run_request();
      end else if (r < 70) begin
        it.kind        = KIND_LOAD;
        it.table_value = short_interval();
      end else if (r < 74) begin
        it.kind         = KIND_LOAD;
        restore_pending = 1'b1;
        restore_index   = it.table_index;
      end else if (r < 86) begin
        it.kind = KIND_TICK;
      end else begin
        it.kind = KIND_NONE;
      end
    end
    return it;
  endfunction

  task automatic send(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    logic      was_busy;
    out_item_t predicted;
    gap = in_burst ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    was_busy  = busy;
    predicted = advance_motor(it);
    pending_outputs.push_back(typed ? want : predicted);
    sent++;
    if (it.kind == KIND_START) begin
      runs_started++;
      if (was_busy) restarts++;
    end
    if (predicted.step_pulse) begin
      steps_issued++;
      if (!predicted.running) begin
        runs_completed++;
        if (int'(run_total) + 1 > longest_run) longest_run = int'(run_total) + 1;
      end
    end
  endtask

  function automatic stim_row_t row(input logic [1:0] kind, input logic [7:0] idx,
                                    input logic [31:0] val, input logic [1:0] mode,
                                    input int dir, input logic [15:0] len, input int typed,
                                    input logic [3:0] coils, input int pulse,
                                    input int run);
    stim_row_t r;
    r.item.kind        = kind;
    r.item.table_index = idx;
    r.item.table_value = val;
    r.item.seq_mode    = mode;
    r.item.direction   = 1'(dir);
    r.item.run_length  = len;
    r.typed            = 1'(typed);
    r.want.coils       = coils;
    r.want.step_pulse  = 1'(pulse);
    r.want.running     = 1'(run);
    return r;
  endfunction

  // result side: random stalls, with stretches of none
  initial begin
    int stall;
    out_if.ready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // capture at the rising edge, compare at the falling edge once the expectation is queued
  always @(posedge clk_i) begin
    out_fire <= rst_ni && out_if.valid && out_if.ready;
    out_seen <= out_if.data;
  end

  always @(negedge clk_i) begin
    if (out_fire) begin
      results_checked++;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: coils %h pulse %b running %b",
                   out_seen.coils, out_seen.step_pulse, out_seen.running);
      end else begin
        oldest_expected = pending_outputs.pop_front();
        if (out_seen.coils !== oldest_expected.coils ||
            out_seen.step_pulse !== oldest_expected.step_pulse ||
            out_seen.running !== oldest_expected.running) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: coils %h/%h pulse %b/%b running %b/%b (exp/act)",
                     results_checked, oldest_expected.coils, out_seen.coils,
                     oldest_expected.step_pulse, out_seen.step_pulse,
                     oldest_expected.running, out_seen.running);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, pending_outputs.size());
    $display("testbench: errors");
    $finish;
  end

  initial begin
    stim_row_t directed_rows [$];
    in_item_t  it;
    bit        ignored;
    int        useful;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cur_match     = '0;
    tick_cnt      = '0;
    phase         = '0;
    steps_done    = '0;
    run_total     = '0;
    ramp_up_len   = '0;
    hold_len      = '0;
    ramp_down_idx = '0;
    mode_q        = MODE_WAVE;
    dir_q         = 1'b0;
    busy          = 1'b0;
    coil_q        = '0;

    //              kind        idx    value          mode           dir len      chk coil p r
    directed_rows = '{
      // tick while idle after reset, then an unused kind with every payload bit set
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 1, 4'h0, 0, 0),
      row(KIND_NONE,  8'hFF, 32'hFFFF_FFFF, MODE_HALF_ALT, 1, 16'hFFFF, 1, 4'h0, 0, 0),
      // entry 0 also sets the live interval; park the largest value, then clear it
      row(KIND_LOAD,  8'h00, 32'hFFFF_FFFF, MODE_WAVE,     0, 16'h0000, 1, 4'h0, 0, 0),
      row(KIND_LOAD,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 1, 4'h0, 0, 0),
      row(KIND_LOAD,  8'h01, 32'h0000_0001, MODE_WAVE,     0, 16'h0000, 1, 4'h0, 0, 0),
      row(KIND_LOAD,  8'hFF, 32'h5A5A_A5A5, MODE_WAVE,     0, 16'h0000, 1, 4'h0, 0, 0),
      // zero length: one step, and that step ends the run
      row(KIND_START, 8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 1, 4'h0, 0, 1),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 1, 4'h1, 1, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 1, 4'h1, 0, 0),
      // full step backward, short ramp up and down
      row(KIND_START, 8'h00, 32'h0000_0000, MODE_FULL,     1, 16'h0002, 0, 4'h0, 0, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 0, 4'h0, 0, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 0, 4'h0, 0, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 0, 4'h0, 0, 0),
      // longest run in half step, cut short before the ramp leaves entries 0 and 1
      row(KIND_START, 8'h00, 32'h0000_0000, MODE_HALF_ALT, 0, 16'hFFFF, 0, 4'h0, 0, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 0, 4'h0, 0, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 0, 4'h0, 0, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 0, 4'h0, 0, 0),
      // restart mid-run into wave backward: phase wraps into the shorter sequence
      row(KIND_START, 8'h00, 32'h0000_0000, MODE_WAVE,     1, 16'h0003, 0, 4'h0, 0, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 0, 4'h0, 0, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 0, 4'h0, 0, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 0, 4'h0, 0, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 0, 4'h0, 0, 0),
      row(KIND_TICK,  8'h00, 32'h0000_0000, MODE_WAVE,     0, 16'h0000, 0, 4'h0, 0, 0)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      it      = pick_item();
      ignored = (it.kind == KIND_NONE) || (it.kind == KIND_TICK && !busy);
      send(it, 1'b0, '0);
      if (!ignored) useful++;
    end
    in_if.valid <= 1'b0;

    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d transactions in, %0d results checked, %0d mismatches",
             sent, results_checked, mismatches);
    $display("summary: %0d runs (%0d restarted while moving), %0d finished, %0d steps, longest %0d",
             runs_started, restarts, runs_completed, steps_issued, longest_run);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
